>>> hdl/rbsi_pkg.sv
// shared constants, types and register codes for the ray box slab intersect block
package rbsi_pkg;

    // number format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EXT_WIDTH   = COORD_WIDTH - 1;
    localparam int QUO_WIDTH   = COORD_WIDTH + FRAC_BITS;

    // pipeline layout: capture, one stage per quotient bit, merge, product, output
    localparam int DIV_STAGES  = QUO_WIDTH;
    localparam int MERGE_STAGE = DIV_STAGES + 1;
    localparam int PROD_STAGE  = DIV_STAGES + 2;
    localparam int OUT_STAGE   = DIV_STAGES + 3;
    localparam int NUM_STAGES  = OUT_STAGE + 1;

    localparam int NUM_AXES      = 3;
    localparam int AXIS_WIDTH    = 2;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COORD_WIDTH:0]   t_wide;
    typedef logic [EXT_WIDTH-1:0]          t_ext;
    typedef logic [AXIS_WIDTH-1:0]         t_axis;
    typedef logic [CFG_IDX_WIDTH-1:0]      t_cfg_idx;

    // register indexes
    localparam t_cfg_idx CFG_HALF_X = 2'd0;
    localparam t_cfg_idx CFG_HALF_Y = 2'd1;
    localparam t_cfg_idx CFG_HALF_Z = 2'd2;

    // face axis codes
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    // one unit in fixed point
    localparam t_ext EXT_RESET = t_ext'(1) << FRAC_BITS;

    typedef struct packed {
        t_coord [NUM_AXES-1:0] origin;
        t_coord [NUM_AXES-1:0] direction;
        t_ext                  max_fraction;
    } t_ray;

    typedef struct packed {
        logic  parallel;
        logic  outside;
        t_wide near_t;
        t_wide far_t;
        logic  near_neg;
    } t_lane_res;

    typedef struct packed {
        logic  hit;
        t_ext  fraction;
        t_axis axis;
        logic  negative;
    } t_merge_res;

endpackage

>>> hdl/rbsi_ray_if.sv
// ray input channel
interface rbsi_ray_if;
    logic                valid;
    logic                ready;
    rbsi_pkg::t_coord    origin_x;
    rbsi_pkg::t_coord    origin_y;
    rbsi_pkg::t_coord    origin_z;
    rbsi_pkg::t_coord    direction_x;
    rbsi_pkg::t_coord    direction_y;
    rbsi_pkg::t_coord    direction_z;
    rbsi_pkg::t_ext      max_fraction;

    modport source (output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                    direction_z, max_fraction, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                  direction_z, max_fraction, output ready);
endinterface

>>> hdl/rbsi_res_if.sv
// intersection result channel
interface rbsi_res_if;
    logic                valid;
    logic                ready;
    logic                hit;
    rbsi_pkg::t_ext      hit_fraction;
    rbsi_pkg::t_coord    point_x;
    rbsi_pkg::t_coord    point_y;
    rbsi_pkg::t_coord    point_z;
    rbsi_pkg::t_axis     face_axis;
    logic                face_negative;

    modport source (output valid, hit, hit_fraction, point_x, point_y, point_z, face_axis,
                    face_negative, input ready);
    modport sink (input valid, hit, hit_fraction, point_x, point_y, point_z, face_axis,
                  face_negative, output ready);
endinterface

>>> hdl/rbsi_div.sv
// pipelined signed fixed point divider, one quotient bit per stage, saturating
module rbsi_div (
    input  logic                          i_clk,
    input  logic [rbsi_pkg::DIV_STAGES:0] i_adv,
    input  rbsi_pkg::t_wide               i_num,
    input  rbsi_pkg::t_coord              i_den,
    output rbsi_pkg::t_coord              o_quo
);
    localparam int CW = rbsi_pkg::COORD_WIDTH;
    localparam int QW = rbsi_pkg::QUO_WIDTH;
    localparam int NS = rbsi_pkg::DIV_STAGES;
    localparam logic [QW-1:0] POS_LIM = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [QW-1:0] NEG_LIM = {{(QW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

    logic [QW-1:0] r_num [0:NS];
    logic [QW-1:0] r_quo [0:NS];
    logic [CW-1:0] r_rem [0:NS];
    logic [CW-1:0] r_den [0:NS];
    logic          r_neg [0:NS];

    logic [QW-1:0] n_num [1:NS];
    logic [QW-1:0] n_quo [1:NS];
    logic [CW-1:0] n_rem [1:NS];

    rbsi_pkg::t_wide num_abs;
    rbsi_pkg::t_wide den_ext;
    rbsi_pkg::t_wide den_abs;
    logic [CW:0]     trial [1:NS];
    logic [CW:0]     diff  [1:NS];

    // magnitudes at capture
    always_comb begin
        den_ext = $signed({i_den[CW-1], i_den});
        num_abs = i_num[CW] ? -i_num : i_num;
        den_abs = den_ext[CW] ? -den_ext : den_ext;
    end

    // one restoring step per stage
    always_comb begin
        for (int k = 1; k <= NS; k++) begin
            trial[k] = {r_rem[k-1], r_num[k-1][QW-1]};
            diff[k]  = trial[k] - {1'b0, r_den[k-1]};
            n_rem[k] = diff[k][CW] ? trial[k][CW-1:0] : diff[k][CW-1:0];
            n_quo[k] = {r_quo[k-1][QW-2:0], ~diff[k][CW]};
            n_num[k] = {r_num[k-1][QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_num[0] <= {num_abs[CW-1:0], {rbsi_pkg::FRAC_BITS{1'b0}}};
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_den[0] <= den_abs[CW-1:0];
            r_neg[0] <= i_num[CW] ^ i_den[CW-1];
        end
        for (int k = 1; k <= NS; k++) begin
            if (i_adv[k]) begin
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // saturate to the coordinate range
    always_comb begin
        if (r_neg[NS]) begin
            if (r_quo[NS] > NEG_LIM) begin
                o_quo = $signed({1'b1, {(CW-1){1'b0}}});
            end else begin
                o_quo = $signed(-r_quo[NS][CW-1:0]);
            end
        end else begin
            if (r_quo[NS] > POS_LIM) begin
                o_quo = $signed({1'b0, {(CW-1){1'b1}}});
            end else begin
                o_quo = $signed(r_quo[NS][CW-1:0]);
            end
        end
    end
endmodule

>>> hdl/rbsi_lane.sv
// one axis lane: near and far slab parameters plus parallel flags
module rbsi_lane (
    input  logic                          i_clk,
    input  logic [rbsi_pkg::DIV_STAGES:0] i_adv,
    input  rbsi_pkg::t_coord              i_origin,
    input  rbsi_pkg::t_coord              i_dir,
    input  rbsi_pkg::t_ext                i_ext,
    output rbsi_pkg::t_lane_res           o_res
);
    localparam int CW = rbsi_pkg::COORD_WIDTH;
    localparam int NS = rbsi_pkg::DIV_STAGES;

    rbsi_pkg::t_wide w_ext;
    rbsi_pkg::t_wide w_org;
    rbsi_pkg::t_wide num_lo;
    rbsi_pkg::t_wide num_hi;
    rbsi_pkg::t_coord t_lo;
    rbsi_pkg::t_coord t_hi;
    rbsi_pkg::t_wide w_lo;
    rbsi_pkg::t_wide w_hi;
    logic swap;

    logic r_par [0:NS];
    logic r_out [0:NS];

    // plane offsets relative to origin
    always_comb begin
        w_ext  = $signed({2'b00, i_ext});
        w_org  = $signed({i_origin[CW-1], i_origin});
        num_lo = -w_ext - w_org;
        num_hi = w_ext - w_org;
    end

    rbsi_div u_div_lo (.i_clk(i_clk), .i_adv(i_adv), .i_num(num_lo), .i_den(i_dir),
                       .o_quo(t_lo));
    rbsi_div u_div_hi (.i_clk(i_clk), .i_adv(i_adv), .i_num(num_hi), .i_den(i_dir),
                       .o_quo(t_hi));

    // parallel slab flags follow the divider
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_par[0] <= (i_dir == '0);
            r_out[0] <= (w_org > w_ext) || (w_org < -w_ext);
        end
        for (int k = 1; k <= NS; k++) begin
            if (i_adv[k]) begin
                r_par[k] <= r_par[k-1];
                r_out[k] <= r_out[k-1];
            end
        end
    end

    // order near and far
    always_comb begin
        w_lo = $signed({t_lo[CW-1], t_lo});
        w_hi = $signed({t_hi[CW-1], t_hi});
        swap = w_lo > w_hi;
        o_res.parallel = r_par[NS];
        o_res.outside  = r_out[NS];
        o_res.near_t   = swap ? w_hi : w_lo;
        o_res.far_t    = swap ? w_lo : w_hi;
        o_res.near_neg = ~swap;
    end
endmodule

>>> hdl/rbsi_merge.sv
// merges the three lanes into entry parameter, face and hit decision
module rbsi_merge (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  rbsi_pkg::t_lane_res  i_lanes [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::t_ext       i_max_fraction,
    output rbsi_pkg::t_merge_res o_res
);
    localparam int CW = rbsi_pkg::COORD_WIDTH;
    localparam rbsi_pkg::t_wide T_LOW  = {2'b10, {(CW-1){1'b1}}};
    localparam rbsi_pkg::t_wide T_HIGH = {2'b01, {(CW-1){1'b0}}};

    rbsi_pkg::t_wide tmin;
    rbsi_pkg::t_wide tmax;
    rbsi_pkg::t_wide maxf;
    rbsi_pkg::t_axis axis;
    logic            neg;
    logic            miss;
    rbsi_pkg::t_merge_res n_res;
    rbsi_pkg::t_merge_res r_res;

    // axes in order x, y, z with early miss
    always_comb begin
        tmin = T_LOW;
        tmax = T_HIGH;
        maxf = $signed({2'b00, i_max_fraction});
        axis = rbsi_pkg::AXIS_X;
        neg  = 1'b0;
        miss = 1'b0;
        for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
            if (!miss) begin
                if (i_lanes[i].parallel) begin
                    if (i_lanes[i].outside) begin
                        miss = 1'b1;
                    end
                end else begin
                    if (i_lanes[i].near_t > tmin) begin
                        tmin = i_lanes[i].near_t;
                        axis = rbsi_pkg::t_axis'(i);
                        neg  = i_lanes[i].near_neg;
                    end
                    if (i_lanes[i].far_t < tmax) begin
                        tmax = i_lanes[i].far_t;
                    end
                    if (tmin > maxf || tmin > tmax) begin
                        miss = 1'b1;
                    end
                end
            end
        end
        if (tmin < 0 || tmin > maxf) begin
            miss = 1'b1;
        end
        n_res.hit      = ~miss;
        n_res.fraction = miss ? '0 : tmin[rbsi_pkg::EXT_WIDTH-1:0];
        n_res.axis     = miss ? rbsi_pkg::AXIS_X : axis;
        n_res.negative = ~miss & neg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

>>> hdl/rbsi_point.sv
// hit point on one axis: product stage then truncate, add and saturate
module rbsi_point (
    input  logic             i_clk,
    input  logic             i_en_prod,
    input  logic             i_en_out,
    input  logic             i_hit,
    input  rbsi_pkg::t_ext   i_fraction,
    input  rbsi_pkg::t_coord i_dir,
    input  rbsi_pkg::t_coord i_origin,
    output rbsi_pkg::t_coord o_point
);
    localparam int CW = rbsi_pkg::COORD_WIDTH;
    localparam int PW = 2 * CW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] SUM_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic signed [PW-1:0] r_prod;
    logic                 r_hit;
    rbsi_pkg::t_coord     r_origin;
    rbsi_pkg::t_coord     r_point;

    logic signed [PW-1:0] shifted;
    logic                 corr;
    logic signed [SW-1:0] sum;
    rbsi_pkg::t_coord     n_point;

    // fraction times direction
    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_prod   <= $signed({1'b0, i_fraction}) * i_dir;
            r_hit    <= i_hit;
            r_origin <= i_origin;
        end
    end

    // truncate toward zero via floor plus carry, then saturate
    always_comb begin
        shifted = r_prod >>> rbsi_pkg::FRAC_BITS;
        corr    = r_prod[PW-1] & (|r_prod[rbsi_pkg::FRAC_BITS-1:0]);
        sum     = $signed({shifted[PW-1], shifted})
                + $signed({{(SW-CW){r_origin[CW-1]}}, r_origin})
                + $signed({{(SW-1){1'b0}}, corr});
        if (!r_hit) begin
            n_point = '0;
        end else if (sum > SUM_MAX) begin
            n_point = SUM_MAX[CW-1:0];
        end else if (sum < SUM_MIN) begin
            n_point = SUM_MIN[CW-1:0];
        end else begin
            n_point = sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_point <= n_point;
        end
    end

    assign o_point = r_point;
endmodule

>>> hdl/ray_box_slab_intersect.sv
// Ray versus centered box slab test, three divider lanes and a merge stage.
// A ray passes in order through capture, 48 quotient bit stages of the lane
// dividers, merge, product and output.
// Throughput: one ray per cycle; the pipeline stalls only where the output is
// held, and bubbles close up. Reset clears all stage valid bits and sets the
// three half extents to 1.0; data registers are not reset.
module ray_box_slab_intersect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  rbsi_pkg::t_cfg_idx   i_cfg_idx,
    input  rbsi_pkg::t_ext       i_cfg_data,
    rbsi_ray_if.sink             i_ray,
    rbsi_res_if.source           o_res
);
    localparam int NS = rbsi_pkg::NUM_STAGES;
    localparam int DS = rbsi_pkg::DIV_STAGES;
    localparam int MS = rbsi_pkg::MERGE_STAGE;
    localparam int PS = rbsi_pkg::PROD_STAGE;
    localparam int OS = rbsi_pkg::OUT_STAGE;

    rbsi_pkg::t_ext       r_ext [rbsi_pkg::NUM_AXES];
    logic [NS-1:0]        r_vld;
    logic [NS-1:0]        rdy;
    rbsi_pkg::t_ray       r_ray [0:MS];
    rbsi_pkg::t_ray       in_ray;
    rbsi_pkg::t_lane_res  lane_res [rbsi_pkg::NUM_AXES];
    rbsi_pkg::t_merge_res merge_res;
    rbsi_pkg::t_merge_res r_res_prod;
    rbsi_pkg::t_merge_res r_res_out;
    rbsi_pkg::t_coord     point [rbsi_pkg::NUM_AXES];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
                r_ext[i] <= rbsi_pkg::EXT_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbsi_pkg::CFG_HALF_X: r_ext[0] <= i_cfg_data;
                rbsi_pkg::CFG_HALF_Y: r_ext[1] <= i_cfg_data;
                rbsi_pkg::CFG_HALF_Z: r_ext[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage ready chain, a stage loads when it is empty or moving on
    always_comb begin
        rdy[NS-1] = ~r_vld[NS-1] | o_res.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_ray.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_ray.ready = rdy[0];

    // ray sideband up to the merge stage
    always_comb begin
        in_ray.origin       = {i_ray.origin_z, i_ray.origin_y, i_ray.origin_x};
        in_ray.direction    = {i_ray.direction_z, i_ray.direction_y, i_ray.direction_x};
        in_ray.max_fraction = i_ray.max_fraction;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_ray[0] <= in_ray;
        end
        for (int k = 1; k <= MS; k++) begin
            if (rdy[k]) begin
                r_ray[k] <= r_ray[k-1];
            end
        end
    end

    // axis lanes
    for (genvar a = 0; a < rbsi_pkg::NUM_AXES; a++) begin : g_lane
        rbsi_lane u_lane (
            .i_clk    (i_clk),
            .i_adv    (rdy[DS:0]),
            .i_origin ($signed(in_ray.origin[a])),
            .i_dir    ($signed(in_ray.direction[a])),
            .i_ext    (r_ext[a]),
            .o_res    (lane_res[a])
        );
    end

    rbsi_merge u_merge (
        .i_clk          (i_clk),
        .i_en           (rdy[MS]),
        .i_lanes        (lane_res),
        .i_max_fraction (r_ray[DS].max_fraction),
        .o_res          (merge_res)
    );

    // hit points per axis
    for (genvar a = 0; a < rbsi_pkg::NUM_AXES; a++) begin : g_point
        rbsi_point u_point (
            .i_clk      (i_clk),
            .i_en_prod  (rdy[PS]),
            .i_en_out   (rdy[OS]),
            .i_hit      (merge_res.hit),
            .i_fraction (merge_res.fraction),
            .i_dir      ($signed(r_ray[MS].direction[a])),
            .i_origin   ($signed(r_ray[MS].origin[a])),
            .o_point    (point[a])
        );
    end

    // merge result follows the point stages
    always_ff @(posedge i_clk) begin
        if (rdy[PS]) begin
            r_res_prod <= merge_res;
        end
        if (rdy[OS]) begin
            r_res_out <= r_res_prod;
        end
    end

    assign o_res.valid         = r_vld[OS];
    assign o_res.hit           = r_res_out.hit;
    assign o_res.hit_fraction  = r_res_out.fraction;
    assign o_res.point_x       = point[0];
    assign o_res.point_y       = point[1];
    assign o_res.point_z       = point[2];
    assign o_res.face_axis     = r_res_out.axis;
    assign o_res.face_negative = r_res_out.negative;

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ray.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled without output backpressure");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |-> (o_res.hit_fraction == '0 && o_res.point_x == '0
            && o_res.point_y == '0 && o_res.point_z == '0
            && o_res.face_axis == rbsi_pkg::AXIS_X && !o_res.face_negative))
        else $error("miss result with nonzero fields");

    // face axis names a real axis
    a_face_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.face_axis == rbsi_pkg::AXIS_X
            || o_res.face_axis == rbsi_pkg::AXIS_Y || o_res.face_axis == rbsi_pkg::AXIS_Z))
        else $error("face axis out of range");
endmodule

>>> tb/ray_box_slab_intersect_test.sv
// testbench for the ray box slab intersect block: directed table, then random rays
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;

    localparam int LATENCY = 51;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    typedef struct {
        logic             hit;
        rbsi_pkg::t_ext   fraction;
        rbsi_pkg::t_coord px, py, pz;
        rbsi_pkg::t_axis  axis;
        logic             negative;
    } t_hit_rec;

    typedef struct {
        rbsi_pkg::t_coord ox, oy, oz, dx, dy, dz;
        rbsi_pkg::t_ext   maxf;
        logic             chk;       // typed-in expectation present
        logic             hit;
        rbsi_pkg::t_ext   fraction;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    rbsi_pkg::t_cfg_idx i_cfg_idx = rbsi_pkg::CFG_HALF_X;
    rbsi_pkg::t_ext i_cfg_data = '0;

    rbsi_ray_if ray_ch();
    rbsi_res_if res_ch();

    ray_box_slab_intersect uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_ray(ray_ch.sink), .o_res(res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    longint   box_half [3];
    t_hit_rec hits_due [$];
    int       n_bad = 0;

    function automatic longint clamp32(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // slab test on one ray against the current box
    function automatic t_hit_rec slab_hit(rbsi_pkg::t_coord ox, rbsi_pkg::t_coord oy,
                                          rbsi_pkg::t_coord oz, rbsi_pkg::t_coord dx,
                                          rbsi_pkg::t_coord dy, rbsi_pkg::t_coord dz,
                                          rbsi_pkg::t_ext mf);
        t_hit_rec r;
        longint o [3];
        longint d [3];
        longint tn, tf, tmp, e, t_in, t_out, maxf;
        int ax;
        logic ng, nn, miss;
        o[0] = ox; o[1] = oy; o[2] = oz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        maxf = mf;
        t_in = QMIN - 1;
        t_out = QMAX + 1;
        ax = 0; ng = 0; miss = 0;
        for (int i = 0; i < 3; i++) begin
            if (!miss) begin
                e = box_half[i];
                if (d[i] == 0) begin
                    if (o[i] > e || o[i] < -e) miss = 1;
                end else begin
                    tn = clamp32(((-e - o[i]) * 65536) / d[i]);
                    tf = clamp32(((e - o[i]) * 65536) / d[i]);
                    nn = 1;
                    if (tn > tf) begin
                        tmp = tn; tn = tf; tf = tmp; nn = 0;
                    end
                    if (tn > t_in) begin
                        t_in = tn; ax = i; ng = nn;
                    end
                    if (tf < t_out) t_out = tf;
                    if (t_in > maxf || t_in > t_out) miss = 1;
                end
            end
        end
        if (!miss && (t_in < 0 || t_in > maxf)) miss = 1;
        r = '{default: '0};
        if (!miss) begin
            r.hit = 1;
            r.fraction = rbsi_pkg::t_ext'(t_in);
            r.px = rbsi_pkg::t_coord'(clamp32(o[0] + (t_in * d[0]) / 65536));
            r.py = rbsi_pkg::t_coord'(clamp32(o[1] + (t_in * d[1]) / 65536));
            r.pz = rbsi_pkg::t_coord'(clamp32(o[2] + (t_in * d[2]) / 65536));
            r.axis = rbsi_pkg::t_axis'(ax);
            r.negative = ng;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic rbsi_pkg::t_coord rand_coord();
        int p = $urandom_range(0, 9);
        if (p < 5)
            return rbsi_pkg::t_coord'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
        if (p < 6) return '0;
        if (p < 7) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return rbsi_pkg::t_coord'($urandom);
    endfunction

    // one ray transfer with a random lead-in gap; valid stays high for the next ray
    task automatic send_ray(rbsi_pkg::t_coord ox, oy, oz, dx, dy, dz, rbsi_pkg::t_ext mf);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ray_ch.valid <= 1'b1;
        ray_ch.origin_x <= ox; ray_ch.origin_y <= oy; ray_ch.origin_z <= oz;
        ray_ch.direction_x <= dx; ray_ch.direction_y <= dy; ray_ch.direction_z <= dz;
        ray_ch.max_fraction <= mf;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
        hits_due.push_back(slab_hit(ox, oy, oz, dx, dy, dz, mf));
    endtask

    // write enable stays high for a following write
    task automatic write_half(rbsi_pkg::t_cfg_idx idx, rbsi_pkg::t_ext v);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        box_half[idx] = v;
    endtask

    task automatic drain();
        ray_ch.valid <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // directed rows against the unit box
    t_row dir_rows [] = '{
        '{-32'sh30000, 0, 0, 32'sh10000, 0, 0, 31'h40000, 1, 1, 31'h20000},
        '{32'sh30000, 0, 0, -32'sh10000, 0, 0, 31'h40000, 1, 1, 31'h20000},
        '{32'sh30000, 0, 0, 32'sh10000, 0, 0, 31'h40000, 1, 0, 31'h0},
        '{0, 32'sh20000, 0, 32'sh10000, 0, 0, 31'h40000, 1, 0, 31'h0},
        '{0, 0, 0, 0, 0, 0, 31'h40000, 1, 0, 31'h0},
        '{-32'sh30000, 0, 0, 32'sh10000, 0, 0, 31'h10000, 1, 0, 31'h0},
        '{0, -32'sh30000, 0, 0, 32'sh10000, 0, 31'h7fffffff, 1, 1, 31'h20000},
        '{0, 0, 32'sh30000, 0, 0, -32'sh10000, 31'h7fffffff, 1, 1, 31'h20000},
        '{-32'sh30000, -32'sh30000, 0, 32'sh10000, 32'sh10000, 0, 31'h7fffffff, 0, 0, 0},
        '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 31'h7fffffff, 0, 0, 0},
        '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 31'h7fffffff, 0, 0, 0},
        '{-32'sh30000, 0, 0, 32'sh1, 0, 0, 31'h7fffffff, 0, 0, 0},
        '{0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 31'h0, 0, 0, 0},
        '{-32'sh10000, 0, 0, 32'sh10000, 0, 0, 31'h0, 0, 0, 0},
        '{32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff,
          32'shffffffff, 31'h7fffffff, 0, 0, 0}
    };

    // sink side: random stalls, compare each transfer with the oldest expectation
    initial begin
        t_hit_rec want;
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                if (hits_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result transfer at %0t", $realtime);
                end else begin
                    want = hits_due.pop_front();
                    if (res_ch.hit !== want.hit || res_ch.hit_fraction !== want.fraction ||
                        res_ch.point_x !== want.px || res_ch.point_y !== want.py ||
                        res_ch.point_z !== want.pz || res_ch.face_axis !== want.axis ||
                        res_ch.face_negative !== want.negative) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"mismatch exp %b %h %h %h %h %0d %b",
                                      " got %b %h %h %h %h %0d %b"},
                                want.hit, want.fraction, want.px, want.py, want.pz, want.axis,
                                want.negative, res_ch.hit, res_ch.hit_fraction, res_ch.point_x,
                                res_ch.point_y, res_ch.point_z, res_ch.face_axis,
                                res_ch.face_negative);
                    end
                end
            end
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                hold = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    // stimulus
    initial begin
        t_hit_rec p;
        rbsi_pkg::t_ext h [3];
        rbsi_pkg::t_ext mf;
        ray_ch.valid <= 1'b0;
        ray_ch.origin_x <= '0; ray_ch.origin_y <= '0; ray_ch.origin_z <= '0;
        ray_ch.direction_x <= '0; ray_ch.direction_y <= '0; ray_ch.direction_z <= '0;
        ray_ch.max_fraction <= '0;
        for (int i = 0; i < 3; i++) box_half[i] = 65536;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            p = slab_hit(dir_rows[k].ox, dir_rows[k].oy, dir_rows[k].oz, dir_rows[k].dx,
                         dir_rows[k].dy, dir_rows[k].dz, dir_rows[k].maxf);
            if (dir_rows[k].chk && (p.hit !== dir_rows[k].hit ||
                                    p.fraction !== dir_rows[k].fraction)) begin
                n_bad++;
                if (n_bad <= 10) $display("table row %0d disagrees with predictor", k);
            end
            send_ray(dir_rows[k].ox, dir_rows[k].oy, dir_rows[k].oz, dir_rows[k].dx,
                     dir_rows[k].dy, dir_rows[k].dz, dir_rows[k].maxf);
        end
        drain();

        // random phases over several box sizes, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            for (int a = 0; a < 3; a++) begin
                case (ph)
                    0: h[a] = '0;
                    1: h[a] = 31'h7fffffff;
                    2: h[a] = 31'h10000;
                    default: h[a] = $urandom_range(0, 9) == 0
                                  ? rbsi_pkg::t_ext'($urandom)
                                  : rbsi_pkg::t_ext'($urandom_range(1, 32'h50000));
                endcase
            end
            write_half(rbsi_pkg::CFG_HALF_X, h[0]);
            write_half(rbsi_pkg::CFG_HALF_Y, h[1]);
            write_half(rbsi_pkg::CFG_HALF_Z, h[2]);
            i_cfg_we <= 1'b0;
            for (int n = 0; n < 170; n++) begin
                mf = $urandom_range(0, 3) == 0 ? rbsi_pkg::t_ext'($urandom)
                                               : rbsi_pkg::t_ext'($urandom_range(0, 32'h80000));
                send_ray(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), mf);
            end
            drain();
        end

        if (n_bad == 0) $display("ray_box_slab_intersect_test passed");
        else $display("ray_box_slab_intersect_test failed");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("ray_box_slab_intersect_test failed");
        $finish;
    end
endmodule
